// ===== design/fst_pkg.sv =====
// Shared types and constants for the first unique symbol tracker.
`default_nettype none

package fst_pkg;

  // Fixed widths of the channel payload symbols
  localparam int unsigned SYM_W = 8;

  // Saturating occurrence count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  // One queued input item between front and back
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } fst_item_t;

  // Back-end sequencer states (one-hot)
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_RDC  = 4'b0100,
    ST_CHK  = 4'b1000
  } fst_state_e;

endpackage

`default_nettype wire

// ===== design/fst_if.sv =====
// Valid/ready channel interfaces for symbol input and result output.
`default_nettype none

interface fst_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_in;
  logic       restart;

  modport source (output valid, output symbol_in, output restart, input ready);
  modport sink   (input valid, input symbol_in, input restart, output ready);
endinterface

interface fst_res_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] symbol_out;

  modport source (output valid, output found, output symbol_out, input ready);
  modport sink   (input valid, input found, input symbol_out, output ready);
endinterface

`default_nettype wire

// ===== design/fst_front.sv =====
// Front end: accepts input items into a two-entry queue for the back end.
`default_nettype none

module fst_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  fst_sym_if.sink          sym_in_i,
  output logic             fq_valid_o,
  output fst_pkg::fst_item_t fq_item_o,
  input  wire              fq_ready_i
);

  fst_pkg::fst_item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // Handshake on both sides
  assign sym_in_i.ready = (cnt_q != 2'd2);
  assign push           = sym_in_i.valid && sym_in_i.ready;
  assign fq_valid_o     = (cnt_q != 2'd0);
  assign pop            = fq_valid_o && fq_ready_i;
  assign fq_item_o      = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{symbol: sym_in_i.symbol_in, restart: sym_in_i.restart};
    end
  end

endmodule

`default_nettype wire

// ===== design/fst_back.sv =====
// Back end: occurrence counts, first-seen order queue and result register.
`default_nettype none

module fst_back #(
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     fq_valid_i,
  input  wire fst_pkg::fst_item_t fq_item_i,
  output logic                    fq_ready_o,
  fst_res_if.source               res_o
);

  localparam int unsigned SB    = SYMBOL_BITS;
  localparam int unsigned ALPHA = 1 << SB;
  localparam int unsigned OW    = fst_pkg::SYM_W;

  // Memories
  logic [1:0]    cnt_mem [ALPHA];
  logic [SB-1:0] ord_mem [ALPHA];

  fst_pkg::fst_state_e state_q, state_d;
  logic [SB-1:0]  sym_q, sym_d;
  logic [SB-1:0]  head_q, head_d;
  logic [SB:0]    fill_q, fill_d;
  logic [SB-1:0]  head_sym_q, head_sym_d;
  logic [ALPHA-1:0] seen_q, seen_d;
  logic           out_valid_q, out_valid_d;
  logic           out_found_q, out_found_d;
  logic [OW-1:0]  out_sym_q, out_sym_d;

  logic [1:0]     cnt_rd_q;
  logic [SB-1:0]  q_rd_q;
  logic [SB-1:0]  cnt_raddr;
  logic           cnt_we;
  logic [1:0]     cnt_wdata;
  logic           ord_we;
  logic [SB-1:0]  ord_waddr;
  logic [SB-1:0]  in_sym;
  logic [1:0]     cur_cnt;
  logic           take;
  logic           emit, emit_found;
  logic [SB-1:0]  emit_sym;
  logic [OW-1:0]  emit_sym_w;

  // Symbol width adaptation between the fixed port width and the alphabet
  if (SB == OW) begin : g_same
    assign in_sym     = fq_item_i.symbol;
    assign emit_sym_w = emit_sym;
  end else if (SB > OW) begin : g_wide
    assign in_sym     = {{(SB-OW){1'b0}}, fq_item_i.symbol};
    assign emit_sym_w = emit_sym[OW-1:0];
  end else begin : g_narrow
    assign in_sym     = fq_item_i.symbol[SB-1:0];
    assign emit_sym_w = {{(OW-SB){1'b0}}, emit_sym};
  end

  // Take a new item only when idle and the result slot will be free
  assign fq_ready_o = (state_q == fst_pkg::ST_IDLE) && (!out_valid_q || res_o.ready);
  assign take       = fq_valid_i && fq_ready_o;
  assign cur_cnt    = seen_q[sym_q] ? cnt_rd_q : fst_pkg::CNT_NONE;
  assign ord_waddr  = head_q + fill_q[SB-1:0];

  // Sequencer: count update, then drop stale queue heads
  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    head_d     = head_q;
    fill_d     = fill_q;
    head_sym_d = head_sym_q;
    seen_d     = seen_q;
    cnt_raddr  = q_rd_q;
    cnt_we     = 1'b0;
    cnt_wdata  = fst_pkg::CNT_MANY;
    ord_we     = 1'b0;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_sym   = '0;
    unique case (state_q)
      fst_pkg::ST_IDLE: begin
        cnt_raddr = in_sym;
        if (take) begin
          state_d = fst_pkg::ST_UPD;
          sym_d   = in_sym;
          if (fq_item_i.restart) begin
            seen_d = '0;
            head_d = '0;
            fill_d = '0;
          end
        end
      end
      fst_pkg::ST_UPD: begin
        cnt_we = 1'b1;
        if (cur_cnt == fst_pkg::CNT_NONE) begin
          // first occurrence: enqueue in first-seen order
          cnt_wdata          = fst_pkg::CNT_ONE;
          seen_d[sym_q]      = 1'b1;
          if (!fill_q[SB]) begin
            ord_we = 1'b1;
            fill_d = fill_q + (SB+1)'(1);
          end
          if (fill_q == '0) begin
            head_sym_d = sym_q;
          end
          emit       = 1'b1;
          emit_found = 1'b1;
          emit_sym   = (fill_q == '0) ? sym_q : head_sym_q;
          state_d    = fst_pkg::ST_IDLE;
        end else if ((fill_q != '0) && (sym_q == head_sym_q)) begin
          // the head repeated: drop it and look at the next entry
          head_d = head_q + SB'(1);
          fill_d = fill_q - (SB+1)'(1);
          if (fill_q == (SB+1)'(1)) begin
            emit    = 1'b1;
            state_d = fst_pkg::ST_IDLE;
          end else begin
            state_d = fst_pkg::ST_RDC;
          end
        end else begin
          emit       = 1'b1;
          emit_found = (fill_q != '0);
          emit_sym   = (fill_q != '0) ? head_sym_q : '0;
          state_d    = fst_pkg::ST_IDLE;
        end
      end
      fst_pkg::ST_RDC: begin
        // queue entry is ready, fetch its count
        cnt_raddr = q_rd_q;
        state_d   = fst_pkg::ST_CHK;
      end
      fst_pkg::ST_CHK: begin
        if (cnt_rd_q == fst_pkg::CNT_ONE) begin
          head_sym_d = q_rd_q;
          emit       = 1'b1;
          emit_found = 1'b1;
          emit_sym   = q_rd_q;
          state_d    = fst_pkg::ST_IDLE;
        end else begin
          head_d = head_q + SB'(1);
          fill_d = fill_q - (SB+1)'(1);
          if (fill_q == (SB+1)'(1)) begin
            emit    = 1'b1;
            state_d = fst_pkg::ST_IDLE;
          end else begin
            state_d = fst_pkg::ST_RDC;
          end
        end
      end
      default: begin
        state_d = fst_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    out_found_d = out_found_q;
    out_sym_d   = out_sym_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_found_d = emit_found;
      out_sym_d   = emit_sym_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fst_pkg::ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    head_sym_q  <= head_sym_d;
    out_found_q <= out_found_d;
    out_sym_q   <= out_sym_d;
  end

  // Count memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[sym_q] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // Order queue memory: read follows the next head pointer
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= sym_q;
    end
    q_rd_q <= ord_mem[head_d];
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.found      = out_found_q;
  assign res_o.symbol_out = out_sym_q;

endmodule

`default_nettype wire

// ===== design/first_unique_symbol_tracker.sv =====
// Usage: first unique symbol tracker top level.
// Input channel sym_in_i carries one symbol_in byte and a restart flag per
// item; restart empties the counts and the first-seen queue before the
// symbol is counted. Output channel res_o carries one result per item:
// found, and symbol_out as the oldest symbol seen exactly once since the
// last restart (0 when found is 0). Both are valid/ready channels.
// The back end reads the count when it takes an item from the input
// queue, then updates it and loads the result register. Each stale
// queue head that gets dropped, but for a drop that leaves the queue
// empty, adds an order-queue read, then a count read (states RDC, CHK),
// before the next head is checked. The back end takes no new item until
// it is done with the last; each symbol is dropped at most once per restart.
// A two-entry input queue keeps accepting items while a result waits in
// the output register; when the receiver stalls, the result holds and the
// back end stops taking items, and the input queue fills and drops ready.
// Reset empties the queue, clears all counts through per-symbol seen
// flags and drops any pending result; no clearing pass is needed.
`default_nettype none

module first_unique_symbol_tracker #(
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  fst_sym_if.sink   sym_in_i,
  fst_res_if.source res_o
);

  logic               fq_valid;
  logic               fq_ready;
  fst_pkg::fst_item_t fq_item;

  fst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sym_in_i   (sym_in_i),
    .fq_valid_o (fq_valid),
    .fq_item_o  (fq_item),
    .fq_ready_i (fq_ready)
  );

  fst_back #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_valid_i (fq_valid),
    .fq_item_i  (fq_item),
    .fq_ready_o (fq_ready),
    .res_o      (res_o)
  );

`ifndef SYNTH
  // A not-found result always reports symbol zero
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.found) |-> (res_o.symbol_out == 8'd0))
    else $error("not-found result with nonzero symbol");

  // The back end is not ready in the cycle after it takes an item
  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_valid && fq_ready) |=> !fq_ready)
    else $error("back end took two items in consecutive cycles");

  // A new result only appears while the back end is working on an item
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> !$past(fq_ready))
    else $error("result produced while back end was idle");
`endif

endmodule

`default_nettype wire

// ===== tb/first_unique_symbol_tracker_tb.sv =====
// Testbench for first_unique_symbol_tracker: directed and random streams vs. a predictor.
`default_nettype none

module first_unique_symbol_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SYM_W = fst_pkg::SYM_W;
  localparam int unsigned ALPHA = 1 << SYM_W;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] symbol;
  } uniq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fst_sym_if sym_if ();
  fst_res_if res_if ();

  first_unique_symbol_tracker dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sym_in_i (sym_if),
    .res_o    (res_if)
  );

  // Predictor state: per-symbol counts and first-seen order
  logic [1:0]       seen_count [ALPHA];
  logic [SYM_W-1:0] first_seen_order [$];
  uniq_result_t     pending_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned long_hold_left = 0;
  int unsigned mismatch_count = 0;

  always #2 clk_i = ~clk_i;

  // Expected result for one accepted item; updates the predictor state
  function automatic uniq_result_t predict_first_unique(logic [SYM_W-1:0] sym, logic restart);
    uniq_result_t r;
    if (restart) begin
      foreach (seen_count[i]) seen_count[i] = fst_pkg::CNT_NONE;
      first_seen_order.delete();
    end
    if (seen_count[sym] == fst_pkg::CNT_NONE) begin
      first_seen_order.push_back(sym);
      seen_count[sym] = fst_pkg::CNT_ONE;
    end else begin
      seen_count[sym] = fst_pkg::CNT_MANY;
    end
    // drop stale heads
    while (first_seen_order.size() > 0 &&
           seen_count[first_seen_order[0]] != fst_pkg::CNT_ONE)
      void'(first_seen_order.pop_front());
    r.found  = (first_seen_order.size() > 0);
    r.symbol = r.found ? first_seen_order[0] : '0;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Receiver ready: long hold first, otherwise random idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      res_if.ready <= 1'b0;
      long_hold_left = long_hold_left - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result check; values are stable from the falling edge to the accepting edge
  always @(negedge clk_i) begin
    uniq_result_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none expected: found=%0b symbol_out=%0h",
                                res_if.found, res_if.symbol_out));
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.found !== exp_res.found)
          note_mismatch($sformatf("found: expected %0b, got %0b", exp_res.found, res_if.found));
        if (res_if.symbol_out !== exp_res.symbol)
          note_mismatch($sformatf("symbol_out: expected %02h, got %02h",
                                  exp_res.symbol, res_if.symbol_out));
      end
    end
  end

  // Send one item; called at a rising edge, returns at the accepting edge
  task automatic send_item(input logic [SYM_W-1:0] sym, input logic restart);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      sym_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sym_if.valid     <= 1'b1;
    sym_if.symbol_in <= sym;
    sym_if.restart   <= restart;
    do begin
      @(negedge clk_i);
      took = sym_if.ready;
      @(posedge clk_i);
    end while (!took);
    pending_results.push_back(predict_first_unique(sym, restart));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    sym_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, repeats, restarts at start and mid-stream
  task automatic test_directed();
    send_item(8'h10, 1'b0);
    send_item(8'h10, 1'b1);   // restart discards the earlier count
    send_item(8'h00, 1'b1);   // restart right after a restart
    send_item(8'h00, 1'b0);   // nothing unique left
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);   // count stays saturated
    send_item(8'h5a, 1'b0);
    send_item(8'ha5, 1'b0);
    send_item(8'h5a, 1'b0);
    send_item(8'ha5, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(8'h33, 1'b1);
    send_item(8'h33, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hff, 1'b0);
    wait_drained();
  endtask

  // Restart-led streams over narrow or wide symbol ranges, with some noise
  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned mode;
    int unsigned span;
    logic [SYM_W-1:0] base;
    logic restart;
    sent = 0;
    while (sent < n_items) begin
      len  = $urandom_range(40, 1);
      mode = $urandom_range(9);
      base = SYM_W'($urandom_range(ALPHA - 1));
      if (mode <= 5)      span = $urandom_range(8, 2);
      else if (mode <= 7) span = 32;
      else                span = ALPHA;
      for (int unsigned k = 0; k < len; k++) begin
        if (mode == 9)   restart = ($urandom_range(3) == 0);
        else if (k == 0) restart = 1'b1;
        else             restart = ($urandom_range(49) == 0);
        send_item(base + SYM_W'($urandom_range(span - 1)), restart);
      end
      sent += len;
    end
    wait_drained();
  endtask

  // Fill the order queue with every symbol, then repeat all in shuffled order
  task automatic test_full_alphabet();
    logic [SYM_W-1:0] perm [ALPHA];
    logic [SYM_W-1:0] tmp;
    int unsigned j;
    for (int unsigned i = 0; i < ALPHA; i++) perm[i] = SYM_W'(i);
    for (int unsigned i = ALPHA - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int unsigned i = 0; i < ALPHA; i++) send_item(perm[i], (i == 0));
    for (int unsigned i = ALPHA - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int unsigned i = 0; i < ALPHA; i++) send_item(perm[i], 1'b0);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_long_hold();
    @(negedge clk_i);
    long_hold_left = LONG_HOLD;
    @(posedge clk_i);
    for (int unsigned k = 0; k < 40; k++)
      send_item(SYM_W'($urandom_range(15)), (k == 0));
    wait_drained();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    sym_if.valid     <= 1'b0;
    sym_if.symbol_in <= '0;
    sym_if.restart   <= 1'b0;
    foreach (seen_count[i]) seen_count[i] = fst_pkg::CNT_NONE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 69;
    test_directed();
    test_random_streams(200);

    send_idle_pct = 69;
    recv_idle_pct = 25;
    test_full_alphabet();
    test_random_streams(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_hold();
    test_random_streams(120);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) note_mismatch("results still outstanding at end");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
